// ----- rtl/quaternion_to_euler313_assert.svh -----
// Assertion macros used by the top-level RTL file. Clock clk, reset rst.
`ifndef QUATERNION_TO_EULER313_ASSERT_SVH
`define QUATERNION_TO_EULER313_ASSERT_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define Q2E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define Q2E_ASSERT_ALWAYS(label, cond, msg)
`define Q2E_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/q2e_pkg.sv -----
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GUARD_BITS       = 16;
  localparam int HEADROOM_BITS    = 5;
  localparam int ANG_W            = 34;
  localparam int SUM_W            = ANG_W + 1;
  localparam int OUT_W            = 18;
  localparam int NUT_W            = 16;
  localparam int MAX_STEPS        = 32;

  localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(64'sd2147483648);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd1073741824);
  localparam logic signed [ANG_W-1:0] FULL_TURN    = ANG_W'(64'sd4294967296);
  localparam logic signed [SUM_W-1:0] ROUND_HALF   = SUM_W'(32768);

  typedef struct packed {
    logic x_neg;
    logic x_zero;
    logic y_zero;
    logic y_pos;
  } vec_flags_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/q2e_vector.sv -----
`timescale 1ns / 1ps
module q2e_vector
  import q2e_pkg::*;
#(
  parameter int XW    = 37,
  parameter int STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    vld_in,
  input  logic signed [XW-1:0]    x_in,
  input  logic signed [XW-1:0]    y_in,
  output logic                    vld_out,
  output logic signed [XW-1:0]    mag,
  output logic signed [ANG_W-1:0] ang
);

  localparam int NSTEP = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

  logic signed [XW-1:0]    xs [0:NSTEP];
  logic signed [XW-1:0]    ys [0:NSTEP];
  logic signed [ANG_W-1:0] zs [0:NSTEP];
  vec_flags_t              fl [0:NSTEP];
  logic                    vld [0:NSTEP];

  logic                    x_neg;
  logic signed [ANG_W-1:0] z_start;
  logic signed [ANG_W-1:0] z_fix;
  logic signed [ANG_W-1:0] z_wrap;

  always_comb begin
    x_neg   = x_in[XW-1];
    z_start = '0;
    if (x_neg) begin
      z_start = y_in[XW-1] ? -HALF_TURN : HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]        <= x_neg ? -x_in : x_in;
      ys[0]        <= x_neg ? -y_in : y_in;
      zs[0]        <= z_start;
      fl[0].x_neg  <= x_neg;
      fl[0].x_zero <= (x_in == '0);
      fl[0].y_zero <= (y_in == '0);
      fl[0].y_pos  <= !y_in[XW-1] && (y_in != '0);
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic signed [XW-1:0]    dx;
    logic signed [XW-1:0]    dy;
    logic signed [ANG_W-1:0] da;

    assign dx = xs[i] >>> i;
    assign dy = ys[i] >>> i;
    assign da = ANG_W'(atan_entry(5'(i)));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[i+1] <= fl[i];
        if (!ys[i][XW-1]) begin
          xs[i+1] <= xs[i] + dy;
          ys[i+1] <= ys[i] - dx;
          zs[i+1] <= zs[i] + da;
        end else begin
          xs[i+1] <= xs[i] - dy;
          ys[i+1] <= ys[i] + dx;
          zs[i+1] <= zs[i] - da;
        end
      end
    end
  end

  always_comb begin
    z_fix = zs[NSTEP];
    if (fl[NSTEP].y_zero) begin
      z_fix = fl[NSTEP].x_neg ? HALF_TURN : '0;
    end else if (fl[NSTEP].x_zero) begin
      z_fix = fl[NSTEP].y_pos ? QUARTER_TURN : -QUARTER_TURN;
    end
    z_wrap = z_fix;
    if (z_fix > HALF_TURN) begin
      z_wrap = z_fix - FULL_TURN;
    end else if (z_fix < -HALF_TURN) begin
      z_wrap = z_fix + FULL_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= xs[NSTEP];
      ang <= z_wrap;
    end
  end

endmodule

// ----- rtl/quaternion_to_euler313.sv -----
`timescale 1ns / 1ps
// Channel | Handshake            | Beat contents
// in      | in_valid, in_stall   | quat_w, quat_x, quat_y, quat_z
// out     | out_valid, out_stall | angle_first, angle_nutation, angle_third
//
// A new beat can be taken in every cycle while in_stall is low; the path is two chained
// pipelined CORDIC vectoring passes (the first run as two in parallel) and one output stage.
// Reset clears only the valid bits along the pipeline.
// When a result waits on out_stall the whole pipeline holds and in_stall is raised.
`include "quaternion_to_euler313_assert.svh"
module quaternion_to_euler313
  import q2e_pkg::*;
#(
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] quat_w,
  input  logic signed [DATA_WIDTH-1:0] quat_x,
  input  logic signed [DATA_WIDTH-1:0] quat_y,
  input  logic signed [DATA_WIDTH-1:0] quat_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_W-1:0]      angle_first,
  output logic        [NUT_W-1:0]      angle_nutation,
  output logic signed [OUT_W-1:0]      angle_third
);

  localparam int XW    = DATA_WIDTH + GUARD_BITS + HEADROOM_BITS;
  localparam int EXT   = XW - DATA_WIDTH - GUARD_BITS;
  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int LAT   = NSTEP + 2;

  logic en;
  logic signed [XW-1:0] w_s, x_s, y_s, z_s;
  logic vld1, vld2, vld3;
  logic signed [XW-1:0]    m1, m2, mt;
  logic signed [ANG_W-1:0] phi_plus, phi_minus, half;
  logic signed [SUM_W-1:0] sum_dl [0:LAT-1];
  logic signed [SUM_W-1:0] dif_dl [0:LAT-1];
  logic signed [ANG_W-1:0] half_c;
  logic signed [SUM_W-1:0] first_r, nut_r, third_r;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign w_s = {{EXT{quat_w[DATA_WIDTH-1]}}, quat_w, {GUARD_BITS{1'b0}}};
  assign x_s = {{EXT{quat_x[DATA_WIDTH-1]}}, quat_x, {GUARD_BITS{1'b0}}};
  assign y_s = {{EXT{quat_y[DATA_WIDTH-1]}}, quat_y, {GUARD_BITS{1'b0}}};
  assign z_s = {{EXT{quat_z[DATA_WIDTH-1]}}, quat_z, {GUARD_BITS{1'b0}}};

  q2e_vector #(.XW(XW), .STEPS(CORDIC_STEPS)) u_plus (
    .clk(clk), .rst(rst), .en(en), .vld_in(in_valid && en),
    .x_in(w_s), .y_in(-z_s), .vld_out(vld1), .mag(m1), .ang(phi_plus)
  );

  q2e_vector #(.XW(XW), .STEPS(CORDIC_STEPS)) u_minus (
    .clk(clk), .rst(rst), .en(en), .vld_in(in_valid && en),
    .x_in(-x_s), .y_in(-y_s), .vld_out(vld2), .mag(m2), .ang(phi_minus)
  );

  q2e_vector #(.XW(XW), .STEPS(CORDIC_STEPS)) u_theta (
    .clk(clk), .rst(rst), .en(en), .vld_in(vld1),
    .x_in(m1), .y_in(m2), .vld_out(vld3), .mag(mt), .ang(half)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sum_dl[0] <= SUM_W'(phi_plus) + SUM_W'(phi_minus);
      dif_dl[0] <= SUM_W'(phi_plus) - SUM_W'(phi_minus);
      for (int k = 1; k < LAT; k++) begin
        sum_dl[k] <= sum_dl[k-1];
        dif_dl[k] <= dif_dl[k-1];
      end
    end
  end

  always_comb begin
    half_c = half;
    if (half < 0) begin
      half_c = '0;
    end else if (half > QUARTER_TURN) begin
      half_c = QUARTER_TURN;
    end
    first_r = (sum_dl[LAT-1] + ROUND_HALF) >>> 16;
    third_r = (dif_dl[LAT-1] + ROUND_HALF) >>> 16;
    nut_r   = ((SUM_W'(half_c) <<< 1) + ROUND_HALF) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_first    <= first_r[OUT_W-1:0];
      angle_nutation <= nut_r[NUT_W-1:0];
      angle_third    <= third_r[OUT_W-1:0];
    end
  end

  `Q2E_ASSERT_ALWAYS(a_lockstep, vld1 == vld2, "half-angle passes out of step")
  `Q2E_ASSERT_NEXT(a_hold, !en, out_valid == $past(out_valid), "valid changed while held")
  `Q2E_ASSERT_ALWAYS(a_nut_range, !out_valid || angle_nutation <= 16'd32768, "nutation out of range")
  `Q2E_ASSERT_ALWAYS(a_mag_sign, !vld1 || !m1[XW-1], "negative magnitude from first pass")

endmodule

// ----- tb/sv/quaternion_to_euler313_test.sv -----
`timescale 1ns / 1ps
module quaternion_to_euler313_test;
  import q2e_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] first;
    logic [NUT_W-1:0] nutation;
    logic [OUT_W-1:0] third;
  } euler_t;

  class euler_scoreboard;
    euler_t pending[$];
    int mismatches = 0;
    int checked = 0;
    int accepted = 0;
    longint arctan[32];

    function new();
      arctan = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
                 64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
                 64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
                 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
                 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051,
                 64'h00000028, 64'h00000014, 64'h0000000A, 64'h00000005,
                 64'h00000002, 64'h00000001, 64'h00000000, 64'h00000000};
    endfunction

    function void rotate_to_axis(input longint px, input longint py,
                                 output longint mag, output longint ang);
      longint cx, cy, acc, dx, dy;
      cx = px;
      cy = py;
      acc = 0;
      if (px < 0) begin
        cx = -px;
        cy = -py;
        acc = (py >= 0) ? 64'sd2147483648 : -64'sd2147483648;
      end
      for (int i = 0; i < 16; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          acc = acc + arctan[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          acc = acc - arctan[i];
        end
      end
      if (py == 0) acc = (px < 0) ? 64'sd2147483648 : 0;
      else if (px == 0) acc = (py > 0) ? 64'sd1073741824 : -64'sd1073741824;
      if (acc > 64'sd2147483648) acc = acc - 64'sd4294967296;
      if (acc < -64'sd2147483648) acc = acc + 64'sd4294967296;
      mag = cx;
      ang = acc;
    endfunction

    function void note_quaternion(input logic signed [15:0] w, x, y, z);
      longint m1, m2, mt, phi_sum, phi_diff, half, t;
      euler_t e;
      rotate_to_axis(longint'(w) <<< 16, -(longint'(z) <<< 16), m1, phi_sum);
      rotate_to_axis(-(longint'(x) <<< 16), -(longint'(y) <<< 16), m2, phi_diff);
      rotate_to_axis(m1, m2, mt, half);
      if (half < 0) half = 0;
      if (half > 64'sd1073741824) half = 64'sd1073741824;
      t = (phi_sum + phi_diff + 32768) >>> 16;
      e.first = t[OUT_W-1:0];
      t = (2 * half + 32768) >>> 16;
      e.nutation = t[NUT_W-1:0];
      t = (phi_sum - phi_diff + 32768) >>> 16;
      e.third = t[OUT_W-1:0];
      pending.push_back(e);
      accepted++;
    endfunction

    function void check_angles(input euler_t got);
      euler_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result beat with no quaternion outstanding: %h", got);
        return;
      end
      want = pending.pop_front();
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected first %0d nut %0d third %0d, got %0d %0d %0d",
                   $signed(want.first), want.nutation, $signed(want.third),
                   $signed(got.first), got.nutation, $signed(got.third));
      end
    endfunction
  endclass

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [OUT_W-1:0] angle_first, angle_third;
  logic [NUT_W-1:0] angle_nutation;
  int send_idle, recv_idle;
  euler_scoreboard board;

  quaternion_to_euler313 dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_stall(out_stall), .angle_first(angle_first),
    .angle_nutation(angle_nutation), .angle_third(angle_third)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_angles({angle_first, angle_nutation, angle_third});
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic send_quaternion(input logic signed [15:0] w, x, y, z);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_w <= w;
    quat_x <= x;
    quat_y <= y;
    quat_z <= z;
    do @(posedge clk); while (in_stall);
    board.note_quaternion(w, x, y, z);
  endtask

  task automatic send_random_quaternion();
    real c[4], norm;
    logic signed [15:0] q[4];
    int kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
        c[i] = real'($signed($urandom_range(65535) - 32768));
        if ($urandom_range(7) == 0) c[i] = 0.0;
        norm = norm + c[i] * c[i];
      end
      norm = (norm == 0.0) ? 1.0 : $sqrt(norm);
      for (int i = 0; i < 4; i++) q[i] = 16'(int'(c[i] * 32767.0 / norm));
    end else if (kind < 8) begin
      for (int i = 0; i < 4; i++) q[i] = 16'($urandom);
    end else begin
      for (int i = 0; i < 4; i++) q[i] = 16'($signed($urandom_range(64) - 32));
    end
    send_quaternion(q[0], q[1], q[2], q[3]);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    quat_w = '0;
    quat_x = '0;
    quat_y = '0;
    quat_z = '0;
    send_idle = 10;
    recv_idle = 70;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_quaternion(0, 0, 0, 0);
    send_quaternion(32767, 0, 0, 0);
    send_quaternion(-32768, 0, 0, 0);
    send_quaternion(0, 32767, 0, 0);
    send_quaternion(0, -32768, 0, 0);
    send_quaternion(0, 0, 32767, 0);
    send_quaternion(0, 0, -32768, 0);
    send_quaternion(0, 0, 0, 32767);
    send_quaternion(0, 0, 0, -32768);
    send_quaternion(-32768, -32768, -32768, -32768);
    send_quaternion(32767, 32767, 32767, 32767);
    send_quaternion(-16384, 16384, -16384, 16384);
    send_quaternion(23170, 0, 0, -23170);
    send_quaternion(-23170, 23170, 23170, 0);
    send_quaternion(-100, 5, -7, 100);
    send_quaternion(-32768, 1, -1, -1);
    send_quaternion(1, -32768, 32767, 1);
    send_quaternion(16384, 16384, 16384, 16384);
    send_quaternion(-32768, 32767, -32768, 32767);
    send_quaternion(0, 0, 1, -1);
    for (int n = 0; n < 930; n++) begin
      if (n == 310) begin
        send_idle = 70;
        recv_idle = 10;
      end else if (n == 620) begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_random_quaternion();
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d quaternions, including axis extremes and zero cases;",
             board.accepted);
    $display("checked %0d angle beats under three stall patterns.", board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Failures: %0d", board.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_vector.sv
rtl/quaternion_to_euler313.sv
tb/sv/quaternion_to_euler313_test.sv
